// File: design/lvlm_pkg.sv
// level meter package: zone codes, types and the voltage digit helpers
`timescale 1ns / 1ps
`default_nettype none

package lvlm_pkg;

  typedef logic [1:0]  zone_t;
  typedef logic [15:0] sample_t;
  typedef logic [5:0]  char_t;

  localparam zone_t ZONE_LOW  = 2'd0;
  localparam zone_t ZONE_MID  = 2'd1;
  localparam zone_t ZONE_HIGH = 2'd2;

  localparam logic [8:0] HUNDREDTHS_AT_FULL = 9'd330;
  localparam char_t      ASCII_ZERO         = 6'h30;

  // digit characters of one voltage report
  typedef struct packed {
    char_t volts;
    char_t tenths;
    char_t hundredths;
  } volt_chars_t;

  // zone of x against thresholds floor(peak/3) and floor(2*peak/3),
  // compared without dividing: x < floor(p/3) iff 3x+3 <= p,
  // x <= floor(2p/3) iff 3x <= 2p
  function automatic zone_t zone_of(input sample_t x, input sample_t peak);
    logic [17:0] x3;
    logic [17:0] p1;
    logic [17:0] p2;
    zone_t       z;
    x3 = {2'b00, x} + {1'b0, x, 1'b0};
    p1 = {2'b00, peak};
    p2 = {1'b0, peak, 1'b0};
    if ((x3 + 18'd3) <= p1) begin
      z = ZONE_LOW;
    end else if (x3 <= p2) begin
      z = ZONE_MID;
    end else begin
      z = ZONE_HIGH;
    end
    return z;
  endfunction

  // ascii digits of floor(s*330/65535) hundredths of a volt
  function automatic volt_chars_t volt_chars(input sample_t s);
    logic [24:0] prod;
    logic [25:0] sum;
    logic [8:0]  v;
    logic [16:0] v205;
    logic [13:0] v41;
    logic [5:0]  t;
    logic [1:0]  d;
    logic [3:0]  tdig;
    logic [3:0]  hdig;
    volt_chars_t c;
    prod = {9'd0, s} * {16'd0, HUNDREDTHS_AT_FULL};
    // divide by 65535: (n + (n >> 16) + 1) >> 16
    sum  = {1'b0, prod} + {17'd0, prod[24:16]} + 26'd1;
    v    = sum[24:16];
    // v / 10 and v / 100 by reciprocal multiply, exact for v <= 330
    v205 = {8'd0, v} * 17'd205;
    v41  = {5'd0, v} * 14'd41;
    t    = v205[16:11];
    d    = v41[13:12];
    tdig = 4'(t - 6'(d * 4'd10));
    hdig = 4'(v - 9'(t * 4'd10));
    c.volts      = ASCII_ZERO + {4'd0, d};
    c.tenths     = ASCII_ZERO + {2'd0, tdig};
    c.hundredths = ASCII_ZERO + {2'd0, hdig};
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/auto_ranging_three_zone_level_meter.sv
// level meter top level: input register, zone and report logic, result register
// an input transaction passes the input register, then the result register
// throughput: one transaction per cycle while out_ready keeps the result stage
// moving, set by the single input/result stage pair; arm transactions produce
// no result and pass the stage even under a result stall; reset: synchronous
// active low; clears peak, previous sample, pending report and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module auto_ranging_three_zone_level_meter
  import lvlm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [15:0] in_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_toggle_red,
  output logic             out_toggle_green,
  output logic             out_toggle_blue,
  output logic             out_report_valid,
  output logic [5:0]       out_volts_char,
  output logic [5:0]       out_tenths_char,
  output logic [5:0]       out_hundredths_char
);

  logic        in_v_r;
  logic        in_action_r;
  sample_t     in_sample_r;
  sample_t     peak_r;
  sample_t     peak_nxt;
  sample_t     prev_r;
  logic        pend_r;
  logic        pend_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        red_r;
  logic        green_r;
  logic        blue_r;
  logic        rep_r;
  char_t       volts_r;
  char_t       tenths_r;
  char_t       hund_r;
  logic        adv;
  logic        take_sample;
  zone_t       zone_new;
  zone_t       zone_prev;
  logic        change;
  volt_chars_t chars;

  // stage handshake
  assign adv         = in_v_r && (in_action_r || !out_valid_r || out_ready);
  assign take_sample = adv && !in_action_r;
  assign in_ready    = !in_v_r || adv;

  // peak update and zone classification against updated thresholds
  always_comb begin
    peak_nxt  = (in_sample_r > peak_r) ? in_sample_r : peak_r;
    zone_new  = zone_of(in_sample_r, peak_nxt);
    zone_prev = zone_of(prev_r, peak_nxt);
    change    = (in_sample_r != prev_r) && (zone_new != zone_prev);
    chars     = volt_chars(in_sample_r);
  end

  // pending report and result valid
  always_comb begin
    pend_nxt = pend_r;
    if (adv && in_action_r) begin
      pend_nxt = 1'b1;
    end else if (take_sample) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (take_sample) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
      prev_r      <= '0;
      pend_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      if (take_sample) begin
        peak_r <= peak_nxt;
        prev_r <= in_sample_r;
      end
    end
  end

  // input transaction register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_action_r <= in_action;
      in_sample_r <= in_sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take_sample) begin
      red_r    <= change && (zone_new == ZONE_LOW  || zone_prev == ZONE_LOW);
      green_r  <= change && (zone_new == ZONE_MID  || zone_prev == ZONE_MID);
      blue_r   <= change && (zone_new == ZONE_HIGH || zone_prev == ZONE_HIGH);
      rep_r    <= pend_r;
      volts_r  <= pend_r ? chars.volts      : '0;
      tenths_r <= pend_r ? chars.tenths     : '0;
      hund_r   <= pend_r ? chars.hundredths : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_toggle_red      = red_r;
  assign out_toggle_green    = green_r;
  assign out_toggle_blue     = blue_r;
  assign out_report_valid    = rep_r;
  assign out_volts_char      = volts_r;
  assign out_tenths_char     = tenths_r;
  assign out_hundredths_char = hund_r;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// testbench for the auto-ranging three-zone level meter: stimulus, zone and voltage predictor
`timescale 1ns / 1ps

module tb_top;
  import lvlm_pkg::*;

  localparam int unsigned FULL_SCALE = 65535;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT = 24;
  localparam int unsigned MAX_REPORTS = 10;

  // one result transaction as seen on the output ports
  typedef struct packed {
    logic  red;
    logic  green;
    logic  blue;
    logic  rpt;
    char_t volts;
    char_t tenths;
    char_t hund;
  } meter_result_t;

  // tracks peak, thresholds and pending report, holds the expected results
  class meter_scoreboard;
    sample_t       peak;
    sample_t       lo_thr;
    sample_t       hi_thr;
    sample_t       prev;
    bit            armed;
    meter_result_t expected_q[$];
    int unsigned   n_errors;

    function new();
      peak = '0;
      lo_thr = '0;
      hi_thr = '0;
      prev = '0;
      armed = 1'b0;
      n_errors = 0;
    endfunction

    function zone_t zone(sample_t x);
      if (x < lo_thr) begin
        return ZONE_LOW;
      end else if (x <= hi_thr) begin
        return ZONE_MID;
      end
      return ZONE_HIGH;
    endfunction

    // accepted input transaction: update state, queue the expected result
    function void note_input(bit act, sample_t s);
      meter_result_t r;
      int unsigned   v;
      zone_t         zn;
      zone_t         zp;
      if (act) begin
        armed = 1'b1;
        return;
      end
      r = '0;
      // voltage digits in hundredths, truncated
      if (armed) begin
        v = (32'(s) * 32'(HUNDREDTHS_AT_FULL)) / FULL_SCALE;
        r.rpt = 1'b1;
        r.volts = ASCII_ZERO + char_t'(v / 100);
        r.tenths = ASCII_ZERO + char_t'((v / 10) % 10);
        r.hund = ASCII_ZERO + char_t'(v % 10);
        armed = 1'b0;
      end
      // new peak moves both thresholds
      if (s > peak) begin
        peak = s;
        lo_thr = sample_t'(32'(s) / 3);
        hi_thr = sample_t'((32'(s) * 2) / 3);
      end
      // toggle old and new zone indicators on a zone change
      if (s != prev) begin
        zn = zone(s);
        zp = zone(prev);
        if (zn != zp) begin
          r.red = (zn == ZONE_LOW) || (zp == ZONE_LOW);
          r.green = (zn == ZONE_MID) || (zp == ZONE_MID);
          r.blue = (zn == ZONE_HIGH) || (zp == ZONE_HIGH);
        end
      end
      prev = s;
      expected_q.push_back(r);
    endfunction

    // accepted result transaction against the oldest expectation
    function void check_result(meter_result_t got);
      meter_result_t e;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("unexpected result r%0b g%0b b%0b rpt%0b %02h %02h %02h",
                   got.red, got.green, got.blue, got.rpt, got.volts, got.tenths, got.hund);
        end
        return;
      end
      e = expected_q.pop_front();
      if ((got.red !== e.red) || (got.green !== e.green) || (got.blue !== e.blue) ||
          (got.rpt !== e.rpt) || (got.volts !== e.volts) || (got.tenths !== e.tenths) ||
          (got.hund !== e.hund)) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("mismatch exp r%0b g%0b b%0b rpt%0b %02h %02h %02h",
                   e.red, e.green, e.blue, e.rpt, e.volts, e.tenths, e.hund);
          $display("         got r%0b g%0b b%0b rpt%0b %02h %02h %02h",
                   got.red, got.green, got.blue, got.rpt, got.volts, got.tenths, got.hund);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [15:0] in_sample;
  logic        out_valid;
  logic        out_ready;
  logic        out_toggle_red;
  logic        out_toggle_green;
  logic        out_toggle_blue;
  logic        out_report_valid;
  logic [5:0]  out_volts_char;
  logic [5:0]  out_tenths_char;
  logic [5:0]  out_hundredths_char;

  logic        hold_rx;
  int unsigned cyc = 0;
  int unsigned items_in = 0;
  meter_scoreboard sb;

  auto_ranging_three_zone_level_meter uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_toggle_red      (out_toggle_red),
    .out_toggle_green    (out_toggle_green),
    .out_toggle_blue     (out_toggle_blue),
    .out_report_valid    (out_report_valid),
    .out_volts_char      (out_volts_char),
    .out_tenths_char     (out_tenths_char),
    .out_hundredths_char (out_hundredths_char)
  );

  always #5 clk = ~clk;

  // cycle count and run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("auto_ranging_three_zone_level_meter verification failed");
      $finish;
    end
  end

  // result side: check each transaction, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_toggle_red, out_toggle_green, out_toggle_blue, out_report_valid,
                       out_volts_char, out_tenths_char, out_hundredths_char});
    end
    if (hold_rx) begin
      out_ready <= 1'b0;
    end else if (cyc >= 3000 && cyc < 5000) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    hold_rx = 1'b0;
    while (items_in < 400) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (200) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // offer one input transaction and wait for it to be taken
  task automatic send_item(input bit act, input sample_t s, input bit calm);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(act, s);
    items_in++;
  endtask

  // value around c, kept inside the sample range
  function automatic sample_t near(int c, int spread);
    int x;
    x = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (x < 0) begin
      x = 0;
    end else if (x > int'(FULL_SCALE)) begin
      x = FULL_SCALE;
    end
    return sample_t'(x);
  endfunction

  // random item steered by the current peak and thresholds
  task automatic send_random(input bit calm);
    int unsigned pick;
    sample_t     s;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_item(1'b1, sample_t'($urandom_range(0, 65535)), calm);
      return;
    end
    if (pick < 18) begin
      s = near(int'(sb.peak) + 512, 512);
    end else if (pick < 28) begin
      s = sb.prev;
    end else if (pick < 43) begin
      s = near(int'(sb.prev), 1);
    end else if (pick < 58) begin
      s = near(int'(sb.lo_thr), 2);
    end else if (pick < 73) begin
      s = near(int'(sb.hi_thr), 2);
    end else begin
      s = sample_t'($urandom_range(0, sb.peak));
    end
    send_item(1'b0, s, calm);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_sample = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // small peak: report digits, zone boundaries, equal and same-zone samples
    send_item(1'b1, 16'hffff, 1'b0);
    send_item(1'b0, 16'd0, 1'b0);
    send_item(1'b1, 16'h5a5a, 1'b0);
    send_item(1'b1, 16'h0000, 1'b0);
    send_item(1'b0, 16'd300, 1'b0);
    send_item(1'b0, 16'd150, 1'b0);
    send_item(1'b0, 16'd160, 1'b0);
    send_item(1'b0, 16'd99, 1'b0);
    send_item(1'b0, 16'd100, 1'b0);
    send_item(1'b0, 16'd200, 1'b0);
    send_item(1'b0, 16'd201, 1'b0);
    send_item(1'b0, 16'd201, 1'b0);
    send_item(1'b0, 16'd0, 1'b0);
    send_item(1'b0, 16'd450, 1'b0);
    send_item(1'b0, 16'd300, 1'b0);

    // random part with a stretch of back-to-back transactions
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_random(i >= 700 && i < 1000);
    end

    // full-scale peak and its threshold boundaries
    send_item(1'b1, 16'h0000, 1'b0);
    send_item(1'b0, 16'd65535, 1'b0);
    send_item(1'b1, 16'hffff, 1'b0);
    send_item(1'b0, 16'd65535, 1'b0);
    send_item(1'b0, 16'd43691, 1'b0);
    send_item(1'b0, 16'd43690, 1'b0);
    send_item(1'b0, 16'd21845, 1'b0);
    send_item(1'b0, 16'd21844, 1'b0);
    send_item(1'b1, 16'h1234, 1'b0);
    send_item(1'b0, 16'd65534, 1'b0);
    send_item(1'b1, 16'h8000, 1'b0);
    send_item(1'b0, 16'd32768, 1'b0);
    in_valid <= 1'b0;

    // drain, then allow for the pipeline latency
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("auto_ranging_three_zone_level_meter verification clean");
    end else begin
      $display("auto_ranging_three_zone_level_meter verification failed");
    end
    $finish;
  end

endmodule

// File: auto_ranging_three_zone_level_meter.f
design/lvlm_pkg.sv
design/auto_ranging_three_zone_level_meter.sv
tb/tb_top.sv
